// ----- rtl/xrg_pkg.sv -----
// ----------------------------------------------------------------------------
// xrg_pkg
// Shared types and constants for the xorshift32 range generator.
// ----------------------------------------------------------------------------
package xrg_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned DivSteps  = DataW;
  localparam int unsigned CntW      = $clog2(DivSteps);
  localparam logic [DataW-1:0] SeedReset = 32'd2463534242;
  localparam int unsigned ShiftA    = 13;
  localparam int unsigned ShiftB    = 17;
  localparam int unsigned ShiftC    = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic skip_div;
    logic div_last;
  } status_t;

  function automatic logic [DataW-1:0] xorshift(input logic [DataW-1:0] s);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] c;
    a = s ^ (s << ShiftA);
    b = a ^ (a >> ShiftB);
    c = b ^ (b << ShiftC);
    return c;
  endfunction

endpackage

// ----- rtl/xrg_datapath.sv -----
// ----------------------------------------------------------------------------
// xrg_datapath
// Generator state, restoring divider for raw mod span, and output register.
// ----------------------------------------------------------------------------
module xrg_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  xrg_pkg::cmd_t               cmd,
  output xrg_pkg::status_t            status,
  input  logic                        cfg_wr_en,
  input  logic [xrg_pkg::DataW-1:0]   cfg_wr_data,
  input  logic                        in_mode,
  input  logic signed [xrg_pkg::DataW-1:0] in_range_min,
  input  logic signed [xrg_pkg::DataW-1:0] in_range_max,
  output logic [xrg_pkg::DataW-1:0]   out_raw_value,
  output logic signed [xrg_pkg::DataW-1:0] out_ranged_value,
  output logic                        out_range_error
);

  logic [xrg_pkg::DataW-1:0] state_r, state_nxt;
  logic [xrg_pkg::DataW-1:0] raw_r;
  logic [xrg_pkg::DataW-1:0] dvd_r;
  logic [xrg_pkg::DataW-1:0] rem_r;
  logic [xrg_pkg::DataW-1:0] lo_r;
  logic [xrg_pkg::DataW-1:0] span_r;
  logic                      mode_r;
  logic [xrg_pkg::CntW-1:0]  cnt_r;

  logic [xrg_pkg::DataW:0]   rem_sh;
  logic [xrg_pkg::DataW:0]   rem_diff;
  logic [xrg_pkg::DataW-1:0] rem_nxt;
  logic [xrg_pkg::DataW-1:0] span_in;
  logic [xrg_pkg::DataW-1:0] ranged_nxt;
  logic                      err_nxt;

  assign state_nxt = xrg_pkg::xorshift(state_r);
  assign span_in   = in_range_max + xrg_pkg::DataW'(1) - in_range_min;

  assign rem_sh   = {rem_r, dvd_r[xrg_pkg::DataW-1]};
  assign rem_diff = rem_sh - {1'b0, span_r};
  assign rem_nxt  = rem_diff[xrg_pkg::DataW] ? rem_sh[xrg_pkg::DataW-1:0]
                                             : rem_diff[xrg_pkg::DataW-1:0];

  assign status.skip_div = !mode_r || (span_r == '0);
  assign status.div_last = (cnt_r == xrg_pkg::CntW'(xrg_pkg::DivSteps - 1));

  always_comb begin
    ranged_nxt = '0;
    err_nxt    = 1'b0;
    if (mode_r) begin
      if (span_r == '0) begin
        ranged_nxt = lo_r;
        err_nxt    = 1'b1;
      end else begin
        ranged_nxt = lo_r + rem_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= xrg_pkg::SeedReset;
    end else if (cfg_wr_en) begin
      state_r <= cfg_wr_data;
    end else if (cmd.load) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      raw_r  <= state_nxt;
      dvd_r  <= state_nxt;
      rem_r  <= '0;
      lo_r   <= in_range_min;
      span_r <= span_in;
      mode_r <= in_mode;
      cnt_r  <= '0;
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[xrg_pkg::DataW-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + xrg_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_raw_value    <= raw_r;
      out_ranged_value <= ranged_nxt;
      out_range_error  <= err_nxt;
    end
  end

endmodule

// ----- rtl/xrg_controller.sv -----
// ----------------------------------------------------------------------------
// xrg_controller
// Sequencer: accept, iterate the divider, hand the result to the output.
// ----------------------------------------------------------------------------
module xrg_controller (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  xrg_pkg::status_t status,
  output xrg_pkg::cmd_t    cmd
);

  xrg_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      xrg_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = xrg_pkg::ST_DIV;
      end
      xrg_pkg::ST_DIV: begin
        if (status.skip_div || status.div_last) state_nxt = xrg_pkg::ST_FINISH;
      end
      xrg_pkg::ST_FINISH: begin
        if (out_free) state_nxt = xrg_pkg::ST_IDLE;
      end
      default: state_nxt = xrg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.out_load = 1'b0;
    unique case (state_r)
      xrg_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      xrg_pkg::ST_DIV: begin
        cmd.step = !status.skip_div;
      end
      xrg_pkg::ST_FINISH: begin
        cmd.out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xrg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- rtl/xorshift32_range_generator_core.sv -----
// ----------------------------------------------------------------------------
// Flow: a request is accepted in IDLE, the 32-step remainder loop runs in DIV (skipped in raw
// mode or zero span), and FINISH loads the output registers once the output is free; out_valid
// is registered from that load. No new request is taken while DIV or FINISH is still busy.
// A new request is accepted while the previous result waits at the output.
// Reset (rst_n low, synchronous) loads the generator with the seed reset value.
// ----------------------------------------------------------------------------
// xorshift32_range_generator_core
// xorshift32 draw with optional mapping into an inclusive signed range.
// ----------------------------------------------------------------------------
module xorshift32_range_generator_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [xrg_pkg::DataW-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic signed [xrg_pkg::DataW-1:0] in_range_min,
  input  logic signed [xrg_pkg::DataW-1:0] in_range_max,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [xrg_pkg::DataW-1:0]   out_raw_value,
  output logic signed [xrg_pkg::DataW-1:0] out_ranged_value,
  output logic                        out_range_error
);

  xrg_pkg::cmd_t    cmd;
  xrg_pkg::status_t status;

  xrg_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  xrg_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_mode          (in_mode),
    .in_range_min     (in_range_min),
    .in_range_max     (in_range_max),
    .out_raw_value    (out_raw_value),
    .out_ranged_value (out_ranged_value),
    .out_range_error  (out_range_error)
  );

endmodule
